@@ hdl/estc_pkg.sv @@
// estc_pkg: shared types, constants and the month length table for the
// epoch seconds to calendar converter. No dependencies.
`timescale 1ns / 1ps

package estc_pkg;

    // calendar constants
    localparam int SEC_PER_DAY    = 86400;
    localparam int SEC_PER_HOUR   = 3600;
    localparam int SEC_PER_MINUTE = 60;
    localparam int EPOCH_YEAR     = 1970;
    localparam int DAYS_PER_400Y  = 146097;
    localparam int LAST_MONTH     = 11;

    // year residues of the epoch year, kept for the leap test
    localparam int EPOCH_MOD4   = 2;
    localparam int EPOCH_MOD100 = 70;
    localparam int EPOCH_MOD400 = 370;

    // command word from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic rem_step;
        logic split;
        logic hour_step;
        logic minute_step;
        logic year_step;
        logic month_step;
        logic result_load;
    } estc_cmd_t;

    // status word from datapath to controller
    typedef struct packed {
        logic hour_more;
        logic minute_more;
        logic year_more;
        logic month_more;
    } estc_status_t;

    // days in a month, 0 is January
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/epoch_seconds_to_calendar.sv @@
// epoch_seconds_to_calendar: top level, Unix seconds to calendar date and time.
// Depends on estc_pkg, estc_ctrl and estc_datapath.
//
//   channel   signals                        direction  handshake
//   input     unix_seconds                   in         in_valid / in_ready
//   output    unchanged, date, time of day   out        out_valid / out_ready
//   config    cfg_data (zone, hours)         in         cfg_we, no wait
//
// one word at a time: accept, then the divide steps (reciprocal multiply,
// remainder, one day correction), then the hour, minute and year walks
// (whole 400 year blocks are skipped as units), the month walk and finish
// the year walk is the longest of these steps
// a finished word waits in the output register while the next is taken in;
// a second finished word holds in the last state until the first is taken
// reset clears zone offset, previous time and all control state
`timescale 1ns / 1ps

module epoch_seconds_to_calendar #(
    parameter int TIME_BITS = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic signed [4:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  unix_seconds,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  unchanged,
    output logic [4:0]            day_of_month,
    output logic [3:0]            month_index,
    output logic [11:0]           year_number,
    output logic [4:0]            hour_of_day,
    output logic [5:0]            minute_of_hour,
    output logic [5:0]            second_of_minute
);
    import estc_pkg::*;

    estc_cmd_t    cmd;
    estc_status_t status;

    // sequencer
    estc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and result word
    estc_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .unix_seconds     (unix_seconds),
        .cmd              (cmd),
        .status           (status),
        .unchanged        (unchanged),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .year_number      (year_number),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

endmodule

@@ hdl/estc_datapath.sv @@
// estc_datapath: zone offset, clamp, seconds-per-day divider, time of day
// split, year and month walk, and the result register.
// Depends on estc_pkg.
`timescale 1ns / 1ps

module estc_datapath #(
    parameter int TIME_BITS = 34
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic signed [4:0]       cfg_data,
    input  logic [TIME_BITS-1:0]    unix_seconds,
    input  estc_pkg::estc_cmd_t     cmd,
    output estc_pkg::estc_status_t  status,
    output logic                    unchanged,
    output logic [4:0]              day_of_month,
    output logic [3:0]              month_index,
    output logic [11:0]             year_number,
    output logic [4:0]              hour_of_day,
    output logic [5:0]              minute_of_hour,
    output logic [5:0]              second_of_minute
);
    import estc_pkg::*;

    localparam int DAY_W  = TIME_BITS - 14;
    localparam int YEAR_W = TIME_BITS - 20;
    localparam int SUM_W  = TIME_BITS + 2;
    localparam logic signed [17:0] ZONE_SCALE = 18'sd3600;

    // seconds per day is 675 shifted up by 7
    localparam int     DAY_SHIFT = 7;
    localparam int     DAY_ODD   = SEC_PER_DAY >> DAY_SHIFT;
    localparam int     NUM_W     = TIME_BITS - DAY_SHIFT;
    localparam int     QUO_W     = TIME_BITS - 16;
    localparam int     PROD_W    = NUM_W + QUO_W;
    localparam int     REM_W     = 18;
    localparam longint RECIP     = (longint'(1) << NUM_W) / DAY_ODD;

    logic signed [4:0]     zone_reg;
    logic [TIME_BITS-1:0]  last_reg;
    logic                  same_reg;
    logic [TIME_BITS-1:0]  num_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [REM_W-1:0]      acc_reg;
    logic [DAY_W-1:0]      days_reg;
    logic [YEAR_W-1:0]     year_reg;
    logic [1:0]            mod4_reg;
    logic [6:0]            mod100_reg;
    logic [8:0]            mod400_reg;
    logic [3:0]            month_reg;
    logic [4:0]            hour_reg;
    logic [5:0]            minute_reg;

    logic signed [17:0]    zone_ext;
    logic signed [17:0]    offset_secs;
    logic signed [SUM_W-1:0] sum_wide;
    logic [TIME_BITS-1:0]  adj_time;
    logic [PROD_W-1:0]     prod;
    logic [TIME_BITS-1:0]  quo_secs;
    logic [TIME_BITS-1:0]  rem_full;
    logic                  rem_over;
    logic                  leap;
    logic [8:0]            year_len;
    logic [4:0]            month_len;
    logic                  big_skip;

    // zone offset in seconds, added and clamped
    always_comb
    begin
        zone_ext    = 18'(zone_reg);
        offset_secs = 18'(zone_ext * ZONE_SCALE);
        sum_wide    = $signed({2'b00, unix_seconds})
                    + $signed({{(SUM_W-18){offset_secs[17]}}, offset_secs});
        priority if (sum_wide[SUM_W-1])
            adj_time = '0;
        else if (sum_wide[SUM_W-2])
            adj_time = '1;
        else
            adj_time = sum_wide[TIME_BITS-1:0];
    end

    // day count by reciprocal multiply, estimate at most one day short
    always_comb
    begin
        prod     = PROD_W'(num_reg[TIME_BITS-1:DAY_SHIFT]) * PROD_W'(RECIP);
        quo_secs = TIME_BITS'(quo_reg) * TIME_BITS'(SEC_PER_DAY);
        rem_full = num_reg - quo_secs;
        rem_over = acc_reg >= REM_W'(SEC_PER_DAY);
    end

    // leap rule from the year residues
    always_comb
    begin
        leap      = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
        year_len  = leap ? 9'd366 : 9'd365;
        month_len = month_days(month_reg, leap);
        big_skip  = days_reg > DAY_W'(DAYS_PER_400Y);
    end

    // status back to the controller
    always_comb
    begin
        status.hour_more   = acc_reg >= REM_W'(SEC_PER_HOUR);
        status.minute_more = acc_reg >= REM_W'(SEC_PER_MINUTE);
        status.year_more   = days_reg > DAY_W'(year_len);
        status.month_more  = (month_reg != 4'(LAST_MONTH)) && (days_reg > DAY_W'(month_len));
    end

    // configuration and previous time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                zone_reg <= cfg_data;
            if (cmd.load)
                last_reg <= adj_time;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            same_reg   <= adj_time == last_reg;
            num_reg    <= adj_time;
            acc_reg    <= '0;
            year_reg   <= YEAR_W'(EPOCH_YEAR);
            mod4_reg   <= 2'(EPOCH_MOD4);
            mod100_reg <= 7'(EPOCH_MOD100);
            mod400_reg <= 9'(EPOCH_MOD400);
            month_reg  <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
        end
        if (cmd.div_step)
            quo_reg <= prod[PROD_W-1:NUM_W];
        if (cmd.rem_step)
            acc_reg <= rem_full[REM_W-1:0];
        if (cmd.split)
        begin
            // the estimate can fall one day short
            if (rem_over)
            begin
                days_reg <= DAY_W'(quo_reg) + DAY_W'(2);
                acc_reg  <= acc_reg - REM_W'(SEC_PER_DAY);
            end
            else
                days_reg <= DAY_W'(quo_reg) + DAY_W'(1);
        end
        if (cmd.hour_step)
        begin
            acc_reg  <= acc_reg - REM_W'(SEC_PER_HOUR);
            hour_reg <= hour_reg + 5'd1;
        end
        if (cmd.minute_step)
        begin
            acc_reg    <= acc_reg - REM_W'(SEC_PER_MINUTE);
            minute_reg <= minute_reg + 6'd1;
        end
        if (cmd.year_step)
        begin
            // a 400 year block has a fixed day count and leaves residues alone
            if (big_skip)
            begin
                days_reg <= days_reg - DAY_W'(DAYS_PER_400Y);
                year_reg <= year_reg + YEAR_W'(400);
            end
            else
            begin
                days_reg   <= days_reg - DAY_W'(year_len);
                year_reg   <= year_reg + YEAR_W'(1);
                mod4_reg   <= mod4_reg + 2'd1;
                mod100_reg <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            end
        end
        if (cmd.month_step)
        begin
            days_reg  <= days_reg - DAY_W'(month_len);
            month_reg <= month_reg + 4'd1;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            unchanged        <= same_reg;
            day_of_month     <= days_reg[4:0];
            month_index      <= month_reg;
            year_number      <= year_reg[11:0];
            hour_of_day      <= hour_reg;
            minute_of_hour   <= minute_reg;
            second_of_minute <= acc_reg[5:0];
        end
    end

endmodule

@@ hdl/estc_ctrl.sv @@
// estc_ctrl: sequencer for the converter, handshakes and step commands.
// Depends on estc_pkg.
`timescale 1ns / 1ps

module estc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  estc_pkg::estc_status_t  status,
    output estc_pkg::estc_cmd_t     cmd
);
    import estc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REMAIN,
        ST_SPLIT,
        ST_HOUR,
        ST_MINUTE,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic              out_valid_reg;

    // step commands
    always_comb
    begin
        cmd.load        = (state_reg == ST_IDLE) && in_valid;
        cmd.div_step    = state_reg == ST_DIVIDE;
        cmd.rem_step    = state_reg == ST_REMAIN;
        cmd.split       = state_reg == ST_SPLIT;
        cmd.hour_step   = (state_reg == ST_HOUR) && status.hour_more;
        cmd.minute_step = (state_reg == ST_MINUTE) && status.minute_more;
        cmd.year_step   = (state_reg == ST_YEAR) && status.year_more;
        cmd.month_step  = (state_reg == ST_MONTH) && status.month_more;
        cmd.result_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    // state and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                    state_reg <= ST_REMAIN;
                ST_REMAIN:
                    state_reg <= ST_SPLIT;
                ST_SPLIT:
                    state_reg <= ST_HOUR;
                ST_HOUR:
                begin
                    if (!status.hour_more)
                        state_reg <= ST_MINUTE;
                end
                ST_MINUTE:
                begin
                    if (!status.minute_more)
                        state_reg <= ST_YEAR;
                end
                ST_YEAR:
                begin
                    if (!status.year_more)
                        state_reg <= ST_MONTH;
                end
                ST_MONTH:
                begin
                    if (!status.month_more)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (cmd.result_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // at most one datapath command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // an accepted word starts the divider
    a_load_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DIVIDE)
        else $error("divider not started after load");

    // multiply is followed by the remainder
    a_divide_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |=> state_reg == ST_REMAIN)
        else $error("remainder not taken after multiply");

    // a loaded result is offered next cycle
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not offered after load");

endmodule
